[hdl/tct_pkg.sv]
// ============================================================================
// Timed cue tracker package
// Shared constants, codes and types for the cue table and the tracker.
// ============================================================================
package tct_pkg;

    // Cue table geometry
    localparam int MAX_CUES = 1024;
    localparam int IDX_W    = $clog2(MAX_CUES);
    localparam int CNT_W    = $clog2(MAX_CUES + 1);

    // Field widths
    localparam int TIME_W    = 32;
    localparam int CLOCK_W   = 64;
    localparam int DWELL_W   = 13;
    localparam int OUT_IDX_W = 11;
    localparam int IN_DATA_W = 128;
    localparam int OUT_DATA_W = 24;

    // Timing constants
    localparam logic [TIME_W:0]    SEEK_JUMP_MS = 33'd1500;
    localparam logic [DWELL_W-1:0] DWELL_RESET  = 13'd400;
    localparam logic [DWELL_W-1:0] DWELL_LIMIT  = 13'd5000;
    localparam logic [TIME_W-1:0]  NO_POSITION  = 32'hFFFF_FFFF;

    // Input word kinds
    typedef enum logic [1:0] {
        ACT_CLEAR  = 2'd0,
        ACT_APPEND = 2'd1,
        ACT_SAMPLE = 2'd2
    } tct_action_t;

    // Tracker sequencer states
    typedef enum logic [1:0] {
        TOP_IDLE,
        TOP_SEARCH,
        TOP_HOLD
    } tct_top_state_t;

    // Cue table sequencer states
    typedef enum logic {
        TBL_IDLE,
        TBL_SEARCH
    } tct_tbl_state_t;

    // Command from the tracker to the cue table
    typedef struct packed {
        logic              clear;
        logic              append;
        logic              search;
        logic [TIME_W-1:0] value;
    } tct_cmd_t;

    // Search result from the cue table
    typedef struct packed {
        logic             done;
        logic             hit_valid;
        logic [IDX_W-1:0] hit_idx;
    } tct_found_t;

    // Pack a cue index as an 11-bit two's complement code, -1 when no hit
    function automatic logic [OUT_IDX_W-1:0] tct_pack_idx(input logic valid,
                                                          input logic [IDX_W-1:0] idx);
        logic [31:0] wide;
        wide = 32'(idx);
        if (!valid)
        begin
            wide = 32'hFFFF_FFFF;
        end
        return wide[OUT_IDX_W-1:0];
    endfunction

endpackage

[hdl/tct_table.sv]
// ============================================================================
// Cue table
// Holds the cue start times in a synchronous memory, appends new cues and
// runs a binary search for the last cue starting at or before a position,
// one probe of the memory per cycle.
// ============================================================================
module tct_table (
    input  logic               clk,
    input  logic               rst_n,
    input  tct_pkg::tct_cmd_t   cmd,
    output tct_pkg::tct_found_t found
);
    import tct_pkg::*;

    // Cue start time storage
    logic [TIME_W-1:0] mem [MAX_CUES];
    logic [TIME_W-1:0] rd_data_reg;
    logic [IDX_W-1:0]  rd_addr;

    tct_tbl_state_t    state_reg, state_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic [CNT_W-1:0]  lo_reg, lo_next;
    logic [CNT_W-1:0]  end_reg, end_next;
    logic [IDX_W-1:0]  mid_reg, mid_next;
    logic [TIME_W-1:0] pos_reg, pos_next;
    logic              done_reg, done_next;
    logic              hit_valid_reg, hit_valid_next;
    logic [IDX_W-1:0]  hit_idx_reg, hit_idx_next;

    logic              probe_le;
    logic [CNT_W-1:0]  mid_wide;
    logic [CNT_W-1:0]  step_lo;
    logic [CNT_W-1:0]  step_end;
    logic [CNT_W-1:0]  step_mid;
    logic [CNT_W-1:0]  first_mid;
    logic              table_full;

    assign table_full = (count_reg == CNT_W'(MAX_CUES));
    assign mid_wide   = CNT_W'(mid_reg);
    assign probe_le   = (rd_data_reg <= pos_reg);

    // Narrow the range around the probed entry
    assign step_lo   = probe_le ? (mid_wide + CNT_W'(1)) : lo_reg;
    assign step_end  = probe_le ? end_reg : mid_wide;
    assign step_mid  = step_lo + ((step_end - step_lo - CNT_W'(1)) >> 1);
    assign first_mid = (count_reg - CNT_W'(1)) >> 1;

    // Sequencer: next state, probe address and table bookkeeping
    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        lo_next        = lo_reg;
        end_next       = end_reg;
        mid_next       = mid_reg;
        pos_next       = pos_reg;
        done_next      = 1'b0;
        hit_valid_next = hit_valid_reg;
        hit_idx_next   = hit_idx_reg;
        rd_addr        = mid_reg;
        case (state_reg)
            TBL_IDLE:
            begin
                if (cmd.clear)
                begin
                    count_next = '0;
                end
                else if (cmd.append)
                begin
                    if (!table_full)
                    begin
                        count_next = count_reg + CNT_W'(1);
                    end
                end
                else if (cmd.search)
                begin
                    pos_next       = cmd.value;
                    hit_valid_next = 1'b0;
                    lo_next        = '0;
                    end_next       = count_reg;
                    mid_next       = first_mid[IDX_W-1:0];
                    rd_addr        = first_mid[IDX_W-1:0];
                    if (count_reg == '0)
                    begin
                        done_next = 1'b1;
                    end
                    else
                    begin
                        state_next = TBL_SEARCH;
                    end
                end
            end
            TBL_SEARCH:
            begin
                lo_next  = step_lo;
                end_next = step_end;
                if (probe_le)
                begin
                    hit_valid_next = 1'b1;
                    hit_idx_next   = mid_reg;
                end
                mid_next = step_mid[IDX_W-1:0];
                rd_addr  = step_mid[IDX_W-1:0];
                if (step_lo >= step_end)
                begin
                    done_next  = 1'b1;
                    state_next = TBL_IDLE;
                end
            end
            default:
            begin
                state_next = TBL_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= TBL_IDLE;
            count_reg     <= '0;
            done_reg      <= 1'b0;
            hit_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            done_reg      <= done_next;
            hit_valid_reg <= hit_valid_next;
        end
    end

    // Search datapath registers
    always_ff @(posedge clk)
    begin
        lo_reg      <= lo_next;
        end_reg     <= end_next;
        mid_reg     <= mid_next;
        pos_reg     <= pos_next;
        hit_idx_reg <= hit_idx_next;
    end

    // Memory: append write and registered probe read
    always_ff @(posedge clk)
    begin
        if (state_reg == TBL_IDLE && !cmd.clear && cmd.append && !table_full)
        begin
            mem[count_reg[IDX_W-1:0]] <= cmd.value;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign found.done      = done_reg;
    assign found.hit_valid = hit_valid_reg;
    assign found.hit_idx   = hit_idx_reg;

endmodule

[hdl/timed_cue_tracker_unit.sv]
// ============================================================================
// Timed cue tracker
// Finds the current cue for each playback position and applies seek
// detection and a minimum dwell time to the cue on display.
// ============================================================================
// Clear, append and unused words are accepted one per cycle while no sample
// is in flight. A position sample runs a binary search over the cue table,
// one memory probe per cycle through the single read port, and no new input
// word is accepted until the search has finished and its result has moved
// on to the output register. The result then sits in that output register,
// so the next word is accepted while it waits to be taken. A sample that
// completes while the previous result is still held stalls until that slot
// frees.
module timed_cue_tracker_unit (
    input  logic                              clk,
    input  logic                              rst_n,
    // Dwell register write port
    input  logic                              cfg_we,
    input  logic [tct_pkg::DWELL_W-1:0]       cfg_wdata,
    // Input words
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    // [31:0] cue_time_ms, [63:32] position_ms, [127:64] clock_ms
    input  logic [tct_pkg::IN_DATA_W-1:0]     s_axis_tdata,
    // [1:0] action
    input  logic [1:0]                        s_axis_tuser,
    // Result words
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // [10:0] shown_index, [21:11] found_index, [23:22] zero
    output logic [tct_pkg::OUT_DATA_W-1:0]    m_axis_tdata,
    // [0] seek_seen
    output logic [0:0]                        m_axis_tuser
);
    import tct_pkg::*;

    tct_top_state_t     state_reg, state_next;
    tct_cmd_t           cmd;
    tct_found_t         found;

    logic [DWELL_W-1:0] dwell_reg;
    logic [TIME_W-1:0]  prev_pos_reg, prev_pos_next;
    logic               prev_valid_reg, prev_valid_next;
    logic               commit_none_reg, commit_none_next;
    logic               commit_valid_reg, commit_valid_next;
    logic [IDX_W-1:0]   commit_idx_reg, commit_idx_next;
    logic [CLOCK_W-1:0] commit_clock_reg, commit_clock_next;
    logic [TIME_W-1:0]  samp_pos_reg, samp_pos_next;
    logic [CLOCK_W-1:0] samp_clock_reg, samp_clock_next;
    logic [OUT_IDX_W-1:0] res_shown_reg, res_shown_next;
    logic [OUT_IDX_W-1:0] res_found_reg, res_found_next;
    logic               res_seek_reg, res_seek_next;
    logic               m_valid_reg, m_valid_next;
    logic [OUT_DATA_W-1:0] m_data_reg;
    logic               m_seek_reg;

    logic               accept;
    logic               out_free;
    logic               out_load;
    logic               seek;
    logic               same_cue;
    logic               expired;
    logic               dwell_off;
    logic               do_commit;
    logic               keep_shown;
    logic [CLOCK_W-1:0] elapsed;
    logic [OUT_IDX_W-1:0] found_code;
    logic [OUT_IDX_W-1:0] commit_code;

    assign s_axis_tready = (state_reg == TOP_IDLE);
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign out_free      = !m_valid_reg || m_axis_tready;
    assign out_load      = (state_reg == TOP_HOLD) && out_free;

    // Seek and dwell decision on the finished search
    assign seek = prev_valid_reg &&
                  ((samp_pos_reg < prev_pos_reg) ||
                   ({1'b0, samp_pos_reg} > ({1'b0, prev_pos_reg} + SEEK_JUMP_MS)));
    assign same_cue = !commit_none_reg && (commit_valid_reg == found.hit_valid) &&
                      (!found.hit_valid || (commit_idx_reg == found.hit_idx));
    assign elapsed    = samp_clock_reg - commit_clock_reg;
    assign expired    = (elapsed >= CLOCK_W'(dwell_reg));
    assign dwell_off  = (dwell_reg == '0);
    assign do_commit  = seek || (!dwell_off && !same_cue && (commit_none_reg || expired));
    assign keep_shown = !seek && !dwell_off && !same_cue && !do_commit;
    assign found_code  = tct_pack_idx(found.hit_valid, found.hit_idx);
    assign commit_code = tct_pack_idx(commit_valid_reg, commit_idx_reg);

    // Sequencer and tracking state
    always_comb
    begin
        state_next        = state_reg;
        prev_pos_next     = prev_pos_reg;
        prev_valid_next   = prev_valid_reg;
        commit_none_next  = commit_none_reg;
        commit_valid_next = commit_valid_reg;
        commit_idx_next   = commit_idx_reg;
        commit_clock_next = commit_clock_reg;
        samp_pos_next     = samp_pos_reg;
        samp_clock_next   = samp_clock_reg;
        res_shown_next    = res_shown_reg;
        res_found_next    = res_found_reg;
        res_seek_next     = res_seek_reg;
        cmd.clear         = 1'b0;
        cmd.append        = 1'b0;
        cmd.search        = 1'b0;
        cmd.value         = s_axis_tdata[TIME_W-1:0];
        case (state_reg)
            TOP_IDLE:
            begin
                if (accept)
                begin
                    case (s_axis_tuser)
                        ACT_CLEAR:
                        begin
                            cmd.clear         = 1'b1;
                            prev_pos_next     = NO_POSITION;
                            prev_valid_next   = 1'b0;
                            commit_none_next  = 1'b1;
                            commit_clock_next = '0;
                        end
                        ACT_APPEND:
                        begin
                            cmd.append = 1'b1;
                        end
                        ACT_SAMPLE:
                        begin
                            cmd.search      = 1'b1;
                            cmd.value       = s_axis_tdata[2*TIME_W-1:TIME_W];
                            samp_pos_next   = s_axis_tdata[2*TIME_W-1:TIME_W];
                            samp_clock_next = s_axis_tdata[IN_DATA_W-1:2*TIME_W];
                            state_next      = TOP_SEARCH;
                        end
                        default:
                        begin
                            // drop unused word kinds
                        end
                    endcase
                end
            end
            TOP_SEARCH:
            begin
                if (found.done)
                begin
                    prev_pos_next   = samp_pos_reg;
                    prev_valid_next = 1'b1;
                    if (do_commit)
                    begin
                        commit_none_next  = 1'b0;
                        commit_valid_next = found.hit_valid;
                        commit_idx_next   = found.hit_idx;
                        commit_clock_next = samp_clock_reg;
                    end
                    res_shown_next = keep_shown ? commit_code : found_code;
                    res_found_next = found_code;
                    res_seek_next  = seek;
                    state_next     = TOP_HOLD;
                end
            end
            TOP_HOLD:
            begin
                if (out_free)
                begin
                    state_next = TOP_IDLE;
                end
            end
            default:
            begin
                state_next = TOP_IDLE;
            end
        endcase
    end

    // Control and tracking registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= TOP_IDLE;
            prev_pos_reg     <= NO_POSITION;
            prev_valid_reg   <= 1'b0;
            commit_none_reg  <= 1'b1;
            commit_valid_reg <= 1'b0;
            commit_clock_reg <= '0;
            m_valid_reg      <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            prev_pos_reg     <= prev_pos_next;
            prev_valid_reg   <= prev_valid_next;
            commit_none_reg  <= commit_none_next;
            commit_valid_reg <= commit_valid_next;
            commit_clock_reg <= commit_clock_next;
            m_valid_reg      <= m_valid_next;
        end
    end

    // Dwell register, saturated on write
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dwell_reg <= DWELL_RESET;
        end
        else if (cfg_we)
        begin
            dwell_reg <= (cfg_wdata > DWELL_LIMIT) ? DWELL_LIMIT : cfg_wdata;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        commit_idx_reg <= commit_idx_next;
        samp_pos_reg   <= samp_pos_next;
        samp_clock_reg <= samp_clock_next;
        res_shown_reg  <= res_shown_next;
        res_found_reg  <= res_found_next;
        res_seek_reg   <= res_seek_next;
    end

    // Output register: load a finished result, drop it once taken
    always_comb
    begin
        m_valid_next = m_valid_reg;
        if (out_load)
        begin
            m_valid_next = 1'b1;
        end
        else if (m_axis_tready)
        begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            m_data_reg <= {2'b00, res_found_reg, res_shown_reg};
            m_seek_reg <= res_seek_reg;
        end
    end

    assign m_axis_tvalid   = m_valid_reg;
    assign m_axis_tdata    = m_data_reg;
    assign m_axis_tuser[0] = m_seek_reg;

    tct_table u_table (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd),
        .found (found)
    );

    // A search only completes while a sample is in flight
    a_done_in_search: assert property (@(posedge clk) disable iff (!rst_n)
        found.done |-> (state_reg == TOP_SEARCH))
        else $error("search completed outside a sample");

    // A completed search is always followed by a held result
    a_done_to_hold: assert property (@(posedge clk) disable iff (!rst_n)
        found.done |=> (state_reg == TOP_HOLD))
        else $error("completed search not moved to result hold");

    // A seek shows the cue that was found
    a_seek_shows_found: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tuser[0]) |->
        (m_axis_tdata[10:0] == m_axis_tdata[21:11]))
        else $error("seek result does not show found cue");

    // The empty commit code never reaches the output
    a_no_empty_commit: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (m_axis_tdata[10:0] != 11'h7FE))
        else $error("uncommitted cue shown");

endmodule

[sim/cue_display_checker.sv]
// ============================================================================
// Cue display checker
// Watches the dwell register port and both word streams of the timed cue
// tracker. Keeps its own cue table, seek state and dwell state, works out the
// result each position sample should give and compares the result words
// against it in order.
// ============================================================================
module cue_display_checker (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [tct_pkg::DWELL_W-1:0]    cfg_wdata,
    input  logic                           s_axis_tvalid,
    input  logic                           s_axis_tready,
    // [31:0] cue_time_ms, [63:32] position_ms, [127:64] clock_ms
    input  logic [tct_pkg::IN_DATA_W-1:0]  s_axis_tdata,
    // [1:0] action
    input  logic [1:0]                     s_axis_tuser,
    input  logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    // [10:0] shown_index, [21:11] found_index, [23:22] zero
    input  logic [tct_pkg::OUT_DATA_W-1:0] m_axis_tdata,
    // [0] seek_seen
    input  logic [0:0]                     m_axis_tuser,
    output int                             mismatch_count,
    output int                             results_owed
);

    import tct_pkg::*;

    typedef struct packed {
        logic [OUT_IDX_W-1:0] shown;
        logic [OUT_IDX_W-1:0] found;
        logic                 seek;
    } cue_display_t;

    // Tracker state as the block should hold it
    logic [TIME_W-1:0]  cue_starts_m [MAX_CUES];
    int                 cue_total;
    int                 held_cue;
    logic [CLOCK_W-1:0] held_since;
    logic [TIME_W-1:0]  last_pos;
    logic               last_pos_valid;
    logic [DWELL_W-1:0] dwell_ms;
    cue_display_t       due_displays [$];
    int                 faults = 0;

    // Forget the committed cue and the previous position
    function automatic void forget_playback();
        held_cue       = -2;
        held_since     = '0;
        last_pos       = NO_POSITION;
        last_pos_valid = 1'b0;
    endfunction

    // Binary search for the last cue starting at or before the position
    function automatic int locate_cue(input logic [TIME_W-1:0] pos);
        int lo;
        int hi;
        int mid;
        int hit;
        lo  = 0;
        hi  = cue_total - 1;
        hit = -1;
        while (lo <= hi)
        begin
            mid = lo + (hi - lo) / 2;
            if (cue_starts_m[mid] <= pos)
            begin
                hit = mid;
                lo  = mid + 1;
            end
            else
            begin
                hi = mid - 1;
            end
        end
        return hit;
    endfunction

    // Apply seek detection and the dwell rule to one position sample
    function automatic cue_display_t track_position(input logic [TIME_W-1:0]  pos,
                                                    input logic [CLOCK_W-1:0] now_ms);
        cue_display_t res;
        int           found;
        int           shown;
        logic         seek;
        found = locate_cue(pos);
        seek  = last_pos_valid &&
                (pos < last_pos || {1'b0, pos} > {1'b0, last_pos} + SEEK_JUMP_MS);
        last_pos       = pos;
        last_pos_valid = 1'b1;
        if (seek)
        begin
            held_cue   = found;
            held_since = now_ms;
            shown      = found;
        end
        else if (dwell_ms == '0)
        begin
            shown = found;
        end
        else if (found == held_cue)
        begin
            shown = held_cue;
        end
        else
        begin
            // commit once the dwell has run out, or when nothing is committed yet
            if (held_cue < -1 || (now_ms - held_since) >= dwell_ms)
            begin
                held_cue   = found;
                held_since = now_ms;
            end
            shown = held_cue;
        end
        res.shown = shown[OUT_IDX_W-1:0];
        res.found = found[OUT_IDX_W-1:0];
        res.seek  = seek;
        return res;
    endfunction

    task automatic note_mismatch(input string field, input logic [OUT_IDX_W-1:0] want,
                                 input logic [OUT_IDX_W-1:0] got);
        faults++;
        $display("%0t: %s mismatch: expected %0d, actual %0d",
                 $time, field, $signed(want), $signed(got));
    endtask

    // Compare one result word with the oldest display still due
    task automatic compare_display();
        cue_display_t want;
        logic [OUT_IDX_W-1:0] got_shown;
        logic [OUT_IDX_W-1:0] got_found;
        got_shown = m_axis_tdata[OUT_IDX_W-1:0];
        got_found = m_axis_tdata[2*OUT_IDX_W-1:OUT_IDX_W];
        if (due_displays.size() == 0)
        begin
            faults++;
            $display("%0t: result word with nothing due: expected none, actual %h/%b",
                     $time, m_axis_tdata, m_axis_tuser);
        end
        else
        begin
            want = due_displays.pop_front();
            if (got_shown !== want.shown)
            begin
                note_mismatch("shown_index", want.shown, got_shown);
            end
            if (got_found !== want.found)
            begin
                note_mismatch("found_index", want.found, got_found);
            end
            if (m_axis_tuser[0] !== want.seek)
            begin
                note_mismatch("seek_seen", OUT_IDX_W'(want.seek), OUT_IDX_W'(m_axis_tuser[0]));
            end
            if (m_axis_tdata[OUT_DATA_W-1:2*OUT_IDX_W] !== '0)
            begin
                note_mismatch("tdata padding", '0,
                              OUT_IDX_W'(m_axis_tdata[OUT_DATA_W-1:2*OUT_IDX_W]));
            end
        end
    endtask

    // Update the table for each accepted input word, queue a display for a sample
    task automatic take_word();
        logic [TIME_W-1:0]  cue_ms;
        logic [TIME_W-1:0]  pos_ms;
        logic [CLOCK_W-1:0] clock_ms;
        cue_display_t       entry;
        cue_ms   = s_axis_tdata[TIME_W-1:0];
        pos_ms   = s_axis_tdata[2*TIME_W-1:TIME_W];
        clock_ms = s_axis_tdata[2*TIME_W+CLOCK_W-1:2*TIME_W];
        case (s_axis_tuser)
            ACT_CLEAR:
            begin
                cue_total = 0;
                forget_playback();
            end
            ACT_APPEND:
            begin
                // drop cues once the table is full
                if (cue_total < MAX_CUES)
                begin
                    cue_starts_m[cue_total] = cue_ms;
                    cue_total++;
                end
            end
            ACT_SAMPLE:
            begin
                entry        = track_position(pos_ms, clock_ms);
                due_displays = {due_displays, entry};
            end
            default:
            begin
                // unused action: no effect
            end
        endcase
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cue_total = 0;
            dwell_ms  = DWELL_RESET;
            forget_playback();
            due_displays.delete();
        end
        else
        begin
            if (cfg_we)
            begin
                dwell_ms = (cfg_wdata > DWELL_LIMIT) ? DWELL_LIMIT : cfg_wdata;
            end
            if (m_axis_tvalid && m_axis_tready)
            begin
                compare_display();
            end
            if (s_axis_tvalid && s_axis_tready)
            begin
                take_word();
            end
        end
        results_owed   <= due_displays.size();
        mismatch_count <= faults;
    end

endmodule

[sim/timed_cue_tracker_unit_tb.sv]
// ============================================================================
// Timed cue tracker testbench
// Drives cue table loads, clears and position samples with random idling on
// both streams, steps the dwell register through its range between phases,
// and takes the verdict from the cue display checker.
// ============================================================================
module timed_cue_tracker_unit_tb;

    import tct_pkg::*;

    localparam logic [1:0] ACT_UNUSED     = 2'd3;
    localparam int         ITEM_TARGET    = 1120;
    localparam int         WATCHDOG_LIMIT = 4000;
    localparam int         LONG_HOLD      = 300;
    localparam int         SETTLE_CYCLES  = 32;

    logic                  clk           = 1'b0;
    logic                  rst_n         = 1'b0;
    logic                  cfg_we        = 1'b0;
    logic [DWELL_W-1:0]    cfg_wdata     = '0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [IN_DATA_W-1:0]  s_axis_tdata  = '0;
    logic [1:0]            s_axis_tuser  = '0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_axis_tdata;
    logic [0:0]            m_axis_tuser;
    int                    mismatch_count;
    int                    results_owed;

    // Stimulus state
    logic [TIME_W-1:0]  play_pos      = '0;
    logic [CLOCK_W-1:0] wall_ms       = '0;
    logic [TIME_W-1:0]  tail_cue      = '0;
    logic [DWELL_W-1:0] dwell_now     = DWELL_RESET;
    logic [TIME_W-1:0]  cue_log [$];
    int                 words_sent    = 0;
    int                 quiet_cycles  = 0;
    bit                 steady_sender = 1'b0;
    bit                 hold_req      = 1'b0;
    bit                 hold_served   = 1'b0;

    always #6 clk = ~clk;

    timed_cue_tracker_unit dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    cue_display_checker checker_i (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_we         (cfg_we),
        .cfg_wdata      (cfg_wdata),
        .s_axis_tvalid  (s_axis_tvalid),
        .s_axis_tready  (s_axis_tready),
        .s_axis_tdata   (s_axis_tdata),
        .s_axis_tuser   (s_axis_tuser),
        .m_axis_tvalid  (m_axis_tvalid),
        .m_axis_tready  (m_axis_tready),
        .m_axis_tdata   (m_axis_tdata),
        .m_axis_tuser   (m_axis_tuser),
        .mismatch_count (mismatch_count),
        .results_owed   (results_owed)
    );

    // Mostly short gaps, now and then a long one
    function automatic int idle_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50)
        begin
            return 0;
        end
        if (r < 88)
        begin
            return $urandom_range(1, 3);
        end
        if (r < 97)
        begin
            return $urandom_range(4, 12);
        end
        return $urandom_range(20, 60);
    endfunction

    // Dwell settings: the extremes first, then a random mix
    function automatic logic [DWELL_W-1:0] pick_dwell(input int phase);
        int r;
        case (phase)
            0: return '1;
            1: return '0;
            2: return 13'd1;
            3: return DWELL_LIMIT;
            4: return DWELL_LIMIT + 13'd1;
            default:
            begin
                r = $urandom_range(0, 9);
                if (r < 4)
                begin
                    return DWELL_W'($urandom_range(1, 200));
                end
                if (r < 6)
                begin
                    return '0;
                end
                if (r < 8)
                begin
                    return DWELL_W'($urandom_range(0, 8191));
                end
                return DWELL_RESET;
            end
        endcase
    endfunction

    function automatic logic [TIME_W-1:0] next_cue_time(input logic [TIME_W-1:0] prev,
                                                        input bit ordered);
        logic [TIME_W:0] sum;
        int r;
        if (!ordered && $urandom_range(0, 9) < 4)
        begin
            return $urandom;
        end
        r = $urandom_range(0, 99);
        if (r < 10)
        begin
            sum = {1'b0, prev};
        end
        else if (r < 70)
        begin
            sum = {1'b0, prev} + $urandom_range(1, 300);
        end
        else
        begin
            sum = {1'b0, prev} + $urandom_range(300, 4000);
        end
        // saturate at the top of the range
        return sum[TIME_W] ? '1 : sum[TIME_W-1:0];
    endfunction

    // Watchdog: end the run when no word moves for too long
    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || cfg_we)
        begin
            quiet_cycles <= 0;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("Regression FAIL");
            $finish;
        end
    end

    // Offer one input word and hold it until accepted
    task automatic send_word(input logic [1:0] kind, input logic [TIME_W-1:0] cue_ms,
                             input logic [TIME_W-1:0] pos_ms,
                             input logic [CLOCK_W-1:0] clock_ms);
        int gap;
        gap = steady_sender ? 0 : idle_gap();
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {clock_ms, pos_ms, cue_ms};
        s_axis_tuser  <= kind;
        @(posedge clk);
        while (!s_axis_tready) @(posedge clk);
        if (kind != ACT_UNUSED)
        begin
            words_sent++;
        end
    endtask

    task automatic clear_cues();
        cue_log.delete();
        send_word(ACT_CLEAR, $urandom, $urandom, {$urandom, $urandom});
    endtask

    task automatic append_cue(input logic [TIME_W-1:0] start_ms);
        cue_log  = {cue_log, start_ms};
        tail_cue = start_ms;
        send_word(ACT_APPEND, start_ms, $urandom, {$urandom, $urandom});
    endtask

    task automatic send_position(input logic [TIME_W-1:0] pos_ms,
                                 input logic [CLOCK_W-1:0] clock_ms);
        send_word(ACT_SAMPLE, $urandom, pos_ms, clock_ms);
    endtask

    // Drop valid and wait until every due result has been taken
    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (results_owed != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_dwell(input logic [DWELL_W-1:0] value);
        drain_results();
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_we    <= 1'b0;
        dwell_now = (value > DWELL_LIMIT) ? DWELL_LIMIT : value;
    endtask

    // Advance the playback position and the wall clock, then sample
    task automatic step_playback();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
        begin
            play_pos = play_pos + $urandom_range(0, 120);
        end
        else if (r < 63)
        begin
            play_pos = play_pos + $urandom_range(1499, 1501);
        end
        else if (r < 71)
        begin
            play_pos = play_pos - $urandom_range(1, 2500);
        end
        else if (r < 81 && cue_log.size() > 0)
        begin
            // land on a cue boundary or just beside it
            play_pos = cue_log[$urandom_range(0, cue_log.size() - 1)] + $urandom_range(0, 2) - 1;
        end
        else if (r < 87)
        begin
            play_pos = play_pos + $urandom_range(1502, 60000);
        end
        else if (r < 93)
        begin
            play_pos = $urandom;
        end
        r = $urandom_range(0, 99);
        if (r < 75)
        begin
            wall_ms = wall_ms + $urandom_range(0, dwell_now / 3 + 2);
        end
        else if (r < 95)
        begin
            wall_ms = wall_ms + $urandom_range(0, 6000);
        end
        else if (r < 98)
        begin
            // clock steps back: elapsed time wraps
            wall_ms = wall_ms - $urandom_range(1, 1000);
        end
        else
        begin
            wall_ms = {$urandom, $urandom};
        end
        send_position(play_pos, wall_ms);
    endtask

    // Clear, load a cue list, then play through it
    task automatic run_session(input int cue_goal, input int position_goal,
                               input bit ordered, input bit squeeze);
        logic [TIME_W-1:0] start_ms;
        int r;
        clear_cues();
        r = $urandom_range(0, 99);
        if (r < 25)
        begin
            start_ms = '0;
        end
        else if (r < 40)
        begin
            start_ms = '1 - $urandom_range(0, 50000);
        end
        else if (r < 90)
        begin
            start_ms = $urandom_range(0, 100000);
        end
        else
        begin
            start_ms = $urandom;
        end
        for (int i = 0; i < cue_goal; i++)
        begin
            append_cue(start_ms);
            start_ms = next_cue_time(start_ms, ordered);
        end
        if (cue_log.size() > 0)
        begin
            play_pos = cue_log[0] - $urandom_range(0, 300);
        end
        else
        begin
            play_pos = $urandom;
        end
        r = $urandom_range(0, 9);
        if (r == 0)
        begin
            wall_ms = '0;
        end
        else if (r == 1)
        begin
            wall_ms = '1 - $urandom_range(0, 20000);
        end
        else
        begin
            wall_ms = {$urandom, $urandom};
        end
        // hold off the receiver while samples keep coming
        if (squeeze)
        begin
            steady_sender = 1'b1;
            hold_req      = 1'b1;
        end
        for (int i = 0; i < position_goal; i++)
        begin
            r = $urandom_range(0, 59);
            if (r == 0)
            begin
                append_cue(next_cue_time(tail_cue, ordered));
            end
            else if (r == 1)
            begin
                send_word(ACT_UNUSED, $urandom, $urandom, {$urandom, $urandom});
            end
            step_playback();
        end
    endtask

    // Result side: random ready bursts and gaps, plus one long hold-off
    initial
    begin
        int  gap;
        int  burst;
        bit  calm;
        calm = 1'b0;
        @(posedge clk);
        while (!rst_n) @(posedge clk);
        forever
        begin
            if (hold_req && !hold_served)
            begin
                hold_served = 1'b1;
                m_axis_tready <= 1'b0;
                repeat (LONG_HOLD) @(posedge clk);
            end
            if ($urandom_range(0, 15) == 0)
            begin
                calm = !calm;
            end
            burst = $urandom_range(1, 16);
            m_axis_tready <= 1'b1;
            repeat (burst) @(posedge clk);
            gap = calm ? 0 : idle_gap();
            if (gap > 0)
            begin
                m_axis_tready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
    end

    // Main stimulus
    initial
    begin
        int phase;
        int r;
        int cue_goal;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: empty table straight after reset, ignored action
        send_position(32'd1000, 64'd0);
        send_word(ACT_UNUSED, '1, '1, '1);
        clear_cues();
        // duplicate starts, both ends of the time range
        append_cue(32'd0);
        append_cue(32'd0);
        append_cue(32'd100);
        append_cue(32'd2000);
        append_cue(32'hFFFF_FFFF);
        send_position(32'd0, 64'd0);
        send_position(32'd99, 64'd10);
        send_position(32'd100, 64'd20);
        // forward by exactly the seek threshold, then by one more
        send_position(32'd1600, 64'd500);
        send_position(32'd3101, 64'd510);
        send_position(32'd3000, 64'd520);
        send_position(32'hFFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF);
        send_position(32'hFFFF_FFFF, 64'd0);
        send_position(32'hFFFF_FFFE, 64'd5);
        send_position(32'hFFFF_FFFF, 64'd6);
        clear_cues();
        send_position(32'd5, 64'd100);
        send_position(32'd6, 64'd900);

        // Full table with drops, receiver held off during playback
        write_dwell(pick_dwell(0));
        run_session(MAX_CUES + 2, 30, 1'b1, 1'b1);
        steady_sender = 1'b0;

        // Short random sessions, a new dwell setting for each
        phase = 1;
        while (words_sent < ITEM_TARGET)
        begin
            write_dwell(pick_dwell(phase));
            phase++;
            steady_sender = ($urandom_range(0, 4) == 0);
            r = $urandom_range(0, 99);
            if (r < 15)
            begin
                cue_goal = 0;
            end
            else if (r < 85)
            begin
                cue_goal = $urandom_range(1, 10);
            end
            else
            begin
                cue_goal = $urandom_range(11, 30);
            end
            run_session(cue_goal, $urandom_range(8, 16), $urandom_range(0, 99) < 85, 1'b0);
        end

        drain_results();
        if (mismatch_count == 0 && results_owed == 0)
        begin
            $display("Regression PASS");
        end
        else
        begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule

[sim.f]
hdl/tct_pkg.sv
hdl/tct_table.sv
hdl/timed_cue_tracker_unit.sv
sim/cue_display_checker.sv
sim/timed_cue_tracker_unit_tb.sv
